// ===== rtl/kdc_pkg.sv =====
// Shared constants and controller/datapath interface types of the keypad calculator.
`default_nettype none
package kdc_pkg;

    // Key codes seen on the keypad word.
    localparam logic [7:0] KEY_MINUS = 8'h2D;
    localparam logic [7:0] KEY_PLUS  = 8'h2B;
    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_SLASH = 8'h2F;
    localparam logic [7:0] KEY_EQUAL = 8'h3D;
    localparam logic [7:0] KEY_ZERO  = 8'd48;
    localparam logic [7:0] KEY_NINE  = 8'd57;

    // Operand entry limits and arithmetic widths.
    localparam int unsigned MAX_DIGITS  = 5;
    localparam int unsigned RADIX       = 10;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned DIGIT_CNT_W = 4;
    localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

    // Pending operator codes.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } kdc_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic key_load;   // a key word is accepted this cycle
        logic alu_load;   // load add/sub/mul result (or divide-by-zero) into output
        logic div_start;  // set up the iterative divider
        logic div_step;   // one quotient bit
        logic div_load;   // load the signed quotient into output
    } kdc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eval_key;   // the offered key is '=' while the second operand is entered
        logic div_run;    // divide pending with a nonzero divisor
        logic div_last;   // the divider is on its final step
    } kdc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/keypad_decimal_calculator.sv =====
// Top level of the four-function keypad calculator.
// A key word is taken whenever s_valid and s_ready are both high. An '=' that closes a
// calculation drops s_ready until the result word is loaded into the output
// register. For add, subtract, multiply and divide by zero the result is loaded
// as soon as the output register is free. Any other divide first runs the restoring
// divider, which produces one quotient bit per cycle. A result waiting on m_valid
// does not block key entry; only the next '=' waits for it to be taken. Divide by
// zero returns 0 with m_divide_error set.
`default_nettype none
module keypad_decimal_calculator
    import kdc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_key_code,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [DATA_W-1:0]  m_result_value,
    output logic                      m_divide_error
);

    kdc_cmd_t  cmd;
    kdc_stat_t stat;

    // Sequencing and handshakes.
    kdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Operand entry and arithmetic.
    kdc_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_key_code     (s_key_code),
        .cmd            (cmd),
        .stat           (stat),
        .m_result_value (m_result_value),
        .m_divide_error (m_divide_error)
    );

endmodule
`default_nettype wire

// ===== rtl/kdc_dp.sv =====
// Datapath of the keypad calculator: operand entry, ALU, iterative divider, output word.
`default_nettype none
module kdc_dp
    import kdc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [7:0]               s_key_code,
    input  wire kdc_cmd_t                 cmd,
    output kdc_stat_t                     stat,
    output logic signed [DATA_W-1:0]      m_result_value,
    output logic                          m_divide_error
);

    logic                   phase_reg, phase_next;
    logic                   neg_first_reg, neg_first_next;
    logic [DATA_W-1:0]      first_reg, first_next;
    logic [DATA_W-1:0]      second_reg, second_next;
    logic [DIGIT_CNT_W-1:0] dcount_reg, dcount_next;
    kdc_op_t                op_reg, op_next;

    logic [DATA_W-1:0]      rem_reg, rem_next;
    logic [DATA_W-1:0]      quot_reg, quot_next;
    logic [DIV_CNT_W-1:0]   dstep_reg, dstep_next;

    logic [DATA_W-1:0]      result_reg, result_next;
    logic                   err_reg, err_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic                   room;
    logic                   is_oper;
    kdc_op_t                key_op;
    logic [DATA_W-1:0]      acc_in;
    logic [DATA_W-1:0]      acc_out;
    logic [DATA_W-1:0]      first_mag;
    logic [DATA_W:0]        trial;
    logic                   trial_ge;
    logic [DATA_W-1:0]      alu_res;

    // Key decode.
    assign is_digit = (s_key_code >= KEY_ZERO) && (s_key_code <= KEY_NINE);
    assign digit    = 4'(s_key_code - KEY_ZERO);
    assign room     = 32'(dcount_reg) < MAX_DIGITS;

    always_comb begin
        is_oper = 1'b1;
        key_op  = OP_ADD;
        case (s_key_code)
            KEY_PLUS:  key_op = OP_ADD;
            KEY_MINUS: key_op = OP_SUB;
            KEY_STAR:  key_op = OP_MUL;
            KEY_SLASH: key_op = OP_DIV;
            default:   is_oper = 1'b0;
        endcase
    end

    // Decimal shift-in of one digit into the operand being entered.
    assign acc_in  = phase_reg ? second_reg : first_reg;
    assign acc_out = DATA_W'(acc_in * DATA_W'(RADIX)) + DATA_W'(digit);

    // Restoring divide step on the magnitude of the first operand.
    assign first_mag = first_reg[DATA_W-1] ? (DATA_W'(0) - first_reg) : first_reg;
    assign trial     = {rem_reg, quot_reg[DATA_W-1]};
    assign trial_ge  = trial >= {1'b0, second_reg};

    // Add, subtract and low word of the product.
    always_comb begin
        case (op_reg)
            OP_ADD:  alu_res = first_reg + second_reg;
            OP_SUB:  alu_res = first_reg - second_reg;
            OP_MUL:  alu_res = DATA_W'(first_reg * second_reg);
            default: alu_res = '0;
        endcase
    end

    // Status toward the controller.
    assign stat.eval_key = phase_reg && (s_key_code == KEY_EQUAL);
    assign stat.div_run  = (op_reg == OP_DIV) && (second_reg != '0);
    assign stat.div_last = dstep_reg == DIV_CNT_W'(DATA_W - 1);

    // Next-state logic of the entry state, divider and output word.
    always_comb begin
        phase_next     = phase_reg;
        neg_first_next = neg_first_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        dcount_next    = dcount_reg;
        op_next        = op_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        dstep_next     = dstep_reg;
        result_next    = result_reg;
        err_next       = err_reg;

        if (cmd.key_load) begin
            if (is_digit) begin
                if (room) begin
                    if (phase_reg) begin
                        second_next = acc_out;
                    end else begin
                        first_next = acc_out;
                    end
                    dcount_next = dcount_reg + DIGIT_CNT_W'(1);
                end
            end else if (!phase_reg) begin
                if ((s_key_code == KEY_MINUS) && (dcount_reg == '0)) begin
                    neg_first_next = 1'b1;
                end else if (is_oper) begin
                    if (neg_first_reg) begin
                        first_next = DATA_W'(0) - first_reg;
                    end
                    op_next     = key_op;
                    phase_next  = 1'b1;
                    dcount_next = '0;
                    second_next = '0;
                end
            end
        end

        if (cmd.div_start) begin
            rem_next   = '0;
            quot_next  = first_mag;
            dstep_next = '0;
        end

        if (cmd.div_step) begin
            rem_next   = trial_ge ? DATA_W'(trial - {1'b0, second_reg}) : DATA_W'(trial);
            quot_next  = {quot_reg[DATA_W-2:0], trial_ge};
            dstep_next = dstep_reg + DIV_CNT_W'(1);
        end

        if (cmd.alu_load) begin
            result_next = alu_res;
            err_next    = (op_reg == OP_DIV);
        end

        if (cmd.div_load) begin
            result_next = first_reg[DATA_W-1] ? (DATA_W'(0) - quot_reg) : quot_reg;
            err_next    = 1'b0;
        end

        // A delivered result starts a fresh calculation.
        if (cmd.alu_load || cmd.div_load) begin
            phase_next     = 1'b0;
            neg_first_next = 1'b0;
            first_next     = '0;
            second_next    = '0;
            dcount_next    = '0;
            op_next        = OP_ADD;
        end
    end

    // Entry state is control state and is cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= 1'b0;
            neg_first_reg <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            dcount_reg    <= '0;
            op_reg        <= OP_ADD;
        end else begin
            phase_reg     <= phase_next;
            neg_first_reg <= neg_first_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            dcount_reg    <= dcount_next;
            op_reg        <= op_next;
        end
    end

    // Divider and output payload registers.
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        dstep_reg  <= dstep_next;
        result_reg <= result_next;
        err_reg    <= err_next;
    end

    assign m_result_value = result_reg;
    assign m_divide_error = err_reg;

endmodule
`default_nettype wire

// ===== rtl/kdc_ctrl.sv =====
// Controller state machine of the keypad calculator: handshakes and sequencing.
`default_nettype none
module kdc_ctrl
    import kdc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire kdc_stat_t stat,
    output kdc_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;
    logic   load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Command decode and next state.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.key_load = accept;
                if (accept && stat.eval_key) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (stat.div_run) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else if (out_free) begin
                    cmd.alu_load = 1'b1;
                    load         = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.div_load = 1'b1;
                    load         = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result word is valid from its load until taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/kdc_checker.sv =====
// Port-level checker of the keypad calculator and its bind to the top level.
`default_nettype none
module kdc_checker
    import kdc_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [DATA_W-1:0]   m_result_value,
    input wire logic                m_divide_error
);

    // A result word is held until taken.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped before it was taken");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_value) && $stable(m_divide_error))
        else $error("result word changed while stalled");

    // A divide by zero always reports a zero result.
    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_error |-> m_result_value == '0)
        else $error("divide error with nonzero result");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule

bind keypad_decimal_calculator kdc_checker u_kdc_checker (.*);
`default_nettype wire
